>>> rtl/core/psd_pkg.sv
// Shared types, widths and codes for the point-to-segment distance pipeline.
package psd_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 8;

	// Coordinate differences never exceed 2^COORD_BITS - 1 in magnitude.
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int PROD_W = 2 * DIFF_W;
	localparam int LEN_W  = 2 * COORD_BITS + 1;
	localparam int NUM_W  = 2 * LEN_W;
	localparam int QUO_W  = 2 * COORD_BITS + 1 + 2 * FRAC_BITS;
	localparam int ROOT_W = COORD_BITS + 1 + FRAC_BITS;
	localparam int DIST_BITS = ROOT_W;

	typedef enum logic [1:0] {
		REGION_DEGENERATE = 2'd0,
		REGION_BEFORE     = 2'd1,
		REGION_PAST       = 2'd2,
		REGION_INTERIOR   = 2'd3
	} region_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic signed [COORD_BITS-1:0] end_x;
		logic signed [COORD_BITS-1:0] end_y;
	} req_t;

	typedef struct packed {
		logic [DIST_BITS-1:0] distance;
		region_t              region;
	} res_t;

endpackage

>>> rtl/core/point_segment_distance_top.sv
// Pipelined point-to-segment distance unit with a bit-per-stage divider and square root.
//
// Each request carries a point and a segment's two end points; each result gives the
// distance from the point to the segment in unsigned fixed point with FRAC_BITS fraction
// bits, floored, plus a code for the nearest part of the segment. The pipeline takes one
// request every clock cycle while results are taken and passes it through five stages that
// form the differences, products, sums, the region decision and the numerator; then the
// restoring divider retires one quotient bit per stage and the square root one result
// bit per stage. When the result is not taken, the whole pipeline holds in place, so no
// request is lost or repeated; req_ready drops only while the last stage holds a result
// that waits.
module point_segment_distance_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  psd_pkg::req_t req_data,
	output logic          res_valid,
	input  logic          res_ready,
	output psd_pkg::res_t res_data
);
	import psd_pkg::*;

	// One advance signal moves every stage at once.
	logic adv;

	// Stage 1: coordinate differences.
	logic                     v_s1;
	logic signed [DIFF_W-1:0] dx_s1, dy_s1, ax_s1, ay_s1, bx_s1, by_s1;
	// Stage 2: products.
	logic                     v_s2;
	logic signed [PROD_W-1:0] dxdx_s2, dydy_s2, axdx_s2, aydy_s2, aydx_s2, axdy_s2;
	logic signed [PROD_W-1:0] axax_s2, ayay_s2, bxbx_s2, byby_s2;
	// Stage 3: squared length, dot product, cross product and squared end distances.
	logic                     v_s3;
	logic        [LEN_W-1:0]  len2_s3, pa2_s3, pb2_s3;
	logic signed [PROD_W-1:0] dot_s3, cross_s3;
	// Stage 4: region decision.
	logic                     v_s4;
	region_t                  region_s4;
	logic        [LEN_W-1:0]  cmag_s4, pt2_s4, len2_s4;
	// Stage 5: numerator and denominator of the squared distance.
	logic                     v_s5;
	region_t                  region_s5;
	logic        [NUM_W-1:0]  num_s5;
	logic        [LEN_W-1:0]  den_s5;

	// Divider stages, one quotient bit each.
	logic                     div_v_s6   [QUO_W];
	logic        [LEN_W-1:0]  div_rem_s6 [QUO_W];
	logic        [QUO_W-1:0]  div_dq_s6  [QUO_W];
	logic        [LEN_W-1:0]  div_den_s6 [QUO_W];
	region_t                  div_reg_s6 [QUO_W];

	// Square root stages, one result bit each.
	logic                     sq_v_s7    [ROOT_W];
	logic        [ROOT_W:0]   sq_rem_s7  [ROOT_W];
	logic        [ROOT_W-1:0] sq_root_s7 [ROOT_W];
	logic      [2*ROOT_W-1:0] sq_rad_s7  [ROOT_W];
	region_t                  sq_reg_s7  [ROOT_W];

	assign adv       = !sq_v_s7[ROOT_W-1] || res_ready;
	assign req_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= DIFF_W'(req_data.end_x) - DIFF_W'(req_data.start_x);
			dy_s1 <= DIFF_W'(req_data.end_y) - DIFF_W'(req_data.start_y);
			ax_s1 <= DIFF_W'(req_data.point_x) - DIFF_W'(req_data.start_x);
			ay_s1 <= DIFF_W'(req_data.point_y) - DIFF_W'(req_data.start_y);
			bx_s1 <= DIFF_W'(req_data.point_x) - DIFF_W'(req_data.end_x);
			by_s1 <= DIFF_W'(req_data.point_y) - DIFF_W'(req_data.end_y);

			dxdx_s2 <= dx_s1 * dx_s1;
			dydy_s2 <= dy_s1 * dy_s1;
			axdx_s2 <= ax_s1 * dx_s1;
			aydy_s2 <= ay_s1 * dy_s1;
			aydx_s2 <= ay_s1 * dx_s1;
			axdy_s2 <= ax_s1 * dy_s1;
			axax_s2 <= ax_s1 * ax_s1;
			ayay_s2 <= ay_s1 * ay_s1;
			bxbx_s2 <= bx_s1 * bx_s1;
			byby_s2 <= by_s1 * by_s1;

			// Every sum stays in range of its product width, so no bit is lost.
			len2_s3  <= LEN_W'(dxdx_s2 + dydy_s2);
			pa2_s3   <= LEN_W'(axax_s2 + ayay_s2);
			pb2_s3   <= LEN_W'(bxbx_s2 + byby_s2);
			dot_s3   <= axdx_s2 + aydy_s2;
			cross_s3 <= aydx_s2 - axdy_s2;

			// A coincident start and end, or a projection before the start, use the
			// start point; a projection past the end uses the end point. A projection
			// exactly on an end point counts as interior.
			len2_s4 <= len2_s3;
			cmag_s4 <= cross_s3[PROD_W-1] ? LEN_W'(-cross_s3) : LEN_W'(cross_s3);
			priority if (len2_s3 == '0) begin
				region_s4 <= REGION_DEGENERATE;
				pt2_s4    <= pa2_s3;
			end else if (dot_s3 < 0) begin
				region_s4 <= REGION_BEFORE;
				pt2_s4    <= pa2_s3;
			end else if (dot_s3 > $signed({1'b0, len2_s3})) begin
				region_s4 <= REGION_PAST;
				pt2_s4    <= pb2_s3;
			end else begin
				region_s4 <= REGION_INTERIOR;
				pt2_s4    <= pa2_s3;
			end

			// Interior points divide the squared cross product by the squared length;
			// end point cases divide the squared distance by one.
			region_s5 <= region_s4;
			if (region_s4 == REGION_INTERIOR) begin
				num_s5 <= cmag_s4 * cmag_s4;
				den_s5 <= len2_s4;
			end else begin
				num_s5 <= NUM_W'(pt2_s4);
				den_s5 <= LEN_W'(1);
			end
		end
	end

	// Restoring division of num * 2^(2*FRAC_BITS) by den. The quotient is known to fit
	// QUO_W bits, so the top of the dividend starts as the remainder and the low bits
	// shift out of the quotient register as quotient bits shift in.
	for (genvar k = 0; k < QUO_W; k++) begin : g_div
		logic             v_in;
		logic [LEN_W-1:0] rem_in;
		logic [QUO_W-1:0] dq_in;
		logic [LEN_W-1:0] den_in;
		region_t          reg_in;
		logic [LEN_W:0]   trial;

		if (k == 0) begin : g_first
			assign v_in   = v_s5;
			assign rem_in = num_s5[NUM_W-1 -: LEN_W];
			assign dq_in  = QUO_W'(num_s5) << (2 * FRAC_BITS);
			assign den_in = den_s5;
			assign reg_in = region_s5;
		end else begin : g_next
			assign v_in   = div_v_s6[k-1];
			assign rem_in = div_rem_s6[k-1];
			assign dq_in  = div_dq_s6[k-1];
			assign den_in = div_den_s6[k-1];
			assign reg_in = div_reg_s6[k-1];
		end

		assign trial = {rem_in, dq_in[QUO_W-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s6[k] <= 1'b0;
			end else if (adv) begin
				div_v_s6[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_den_s6[k] <= den_in;
				div_reg_s6[k] <= reg_in;
				if (trial >= {1'b0, den_in}) begin
					div_rem_s6[k] <= LEN_W'(trial - {1'b0, den_in});
					div_dq_s6[k]  <= {dq_in[QUO_W-2:0], 1'b1};
				end else begin
					div_rem_s6[k] <= LEN_W'(trial);
					div_dq_s6[k]  <= {dq_in[QUO_W-2:0], 1'b0};
				end
			end
		end
	end

	// Digit-by-digit integer square root of the quotient, two radicand bits per stage.
	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		logic                v_in;
		logic [ROOT_W:0]     rem_in;
		logic [ROOT_W-1:0]   root_in;
		logic [2*ROOT_W-1:0] rad_in;
		region_t             reg_in;
		logic [ROOT_W+2:0]   acc;
		logic [ROOT_W+2:0]   trial;

		if (k == 0) begin : g_first
			assign v_in    = div_v_s6[QUO_W-1];
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = (2 * ROOT_W)'(div_dq_s6[QUO_W-1]);
			assign reg_in  = div_reg_s6[QUO_W-1];
		end else begin : g_next
			assign v_in    = sq_v_s7[k-1];
			assign rem_in  = sq_rem_s7[k-1];
			assign root_in = sq_root_s7[k-1];
			assign rad_in  = sq_rad_s7[k-1];
			assign reg_in  = sq_reg_s7[k-1];
		end

		assign acc   = {rem_in, rad_in[2*ROOT_W-1 -: 2]};
		assign trial = {1'b0, root_in, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s7[k] <= 1'b0;
			end else if (adv) begin
				sq_v_s7[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_rad_s7[k] <= {rad_in[2*ROOT_W-3:0], 2'b00};
				sq_reg_s7[k] <= reg_in;
				if (acc >= trial) begin
					sq_rem_s7[k]  <= (ROOT_W + 1)'(acc - trial);
					sq_root_s7[k] <= {root_in[ROOT_W-2:0], 1'b1};
				end else begin
					sq_rem_s7[k]  <= (ROOT_W + 1)'(acc);
					sq_root_s7[k] <= {root_in[ROOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign res_valid         = sq_v_s7[ROOT_W-1];
	assign res_data.distance = sq_root_s7[ROOT_W-1];
	assign res_data.region   = sq_reg_s7[ROOT_W-1];

endmodule
